@@ rtl/core/iir3_pkg.sv @@
// Shared constants and types for the third-order IIR filter.
package iir3_pkg;

  localparam int DEF_SAMPLE_WIDTH   = 32;
  localparam int DEF_COEF_FRAC_BITS = 28;

  localparam int COEF_W     = 32;
  localparam int NUM_COEFS  = 6;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;

  // register map, byte address = 4 * index
  typedef enum logic [REG_IDX_W-1:0] {
    REG_FB_ONE,
    REG_FB_TWO,
    REG_FB_THREE,
    REG_FF_ONE,
    REG_FF_TWO,
    REG_FF_THREE
  } reg_index_t;

  typedef logic [COEF_W-1:0] coef_t;
  typedef coef_t [NUM_COEFS-1:0] coef_bank_t;

  // Q3.28 defaults: 2.016, -1.262, 0.2411, 0.001108, 0.003157, 0.0005445
  localparam coef_bank_t COEF_RESET = {
    32'sd146163,      // REG_FF_THREE
    32'sd847451,      // REG_FF_TWO
    32'sd297427,      // REG_FF_ONE
    32'sd64719789,    // REG_FB_THREE
    -32'sd338765546,  // REG_FB_TWO
    32'sd541165879    // REG_FB_ONE
  };

endpackage

@@ rtl/core/third_order_iir_filter.sv @@
// A beat accepted at an edge is registered there and shows on m_tvalid right after it.
// Throughput: one sample per cycle unless m_tready stalls; y_new feeds y[n-1] at once, so
// the path from the delay lines through six multiplies and the adder tree sets the clock.
// Reset (rst, synchronous): delay lines cleared to zero, coefficients loaded with their
// defaults, output register emptied. No clearing pass.
module third_order_iir_filter
  import iir3_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = DEF_SAMPLE_WIDTH,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS,
  localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [TDATA_W-1:0]    s_tdata,   // [SAMPLE_WIDTH-1:0] sample_in, rest zero pad
  // output stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [TDATA_W-1:0]    m_tdata,   // [SAMPLE_WIDTH-1:0] sample_out, rest zero
  output logic                  m_tuser,   // [0] saturated
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam logic [SAMPLE_WIDTH-1:0] OUT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] OUT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  coef_bank_t                   coefs;
  logic [2:0][SAMPLE_WIDTH-1:0] x_hist;   // x[n-1], x[n-2], x[n-3]
  logic [2:0][SAMPLE_WIDTH-1:0] y_hist;   // y[n-1], y[n-2], y[n-3]
  logic [SAMPLE_WIDTH-1:0]      y_new;
  logic                         y_clipped;
  logic                         in_fire;

  logic                         out_valid;
  logic [SAMPLE_WIDTH-1:0]      out_sample;
  logic                         out_sat;

  assign pready = 1'b1;

  iir3_coef_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .coefs  (coefs)
  );

  // output is a function of the delay lines only; the incoming sample
  // just enters x_hist
  iir3_accum #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_accum (
    .x_hist (x_hist),
    .y_hist (y_hist),
    .coefs  (coefs),
    .result (y_new),
    .clipped(y_clipped)
  );

  // output register doubles as the skid stage: take a new beat whenever
  // the held result is gone or leaves this cycle
  assign s_tready = !out_valid || m_tready;
  assign in_fire  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_hist <= '0;
      y_hist <= '0;
    end else if (in_fire) begin
      x_hist <= {x_hist[1:0], s_tdata[SAMPLE_WIDTH-1:0]};
      y_hist <= {y_hist[1:0], y_new};  // clipped value goes back, not the raw sum
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_sample <= y_new;
      out_sat    <= y_clipped;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = TDATA_W'(out_sample);
  assign m_tuser  = out_sat;

`ifndef SYNTHESIS
  // every accepted sample leaves a result in the output register
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> m_tvalid)
    else $error("accepted beat left no result");

  // the incoming sample lands at the head of the input delay line
  a_x_shift: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (x_hist[0] == $past(s_tdata[SAMPLE_WIDTH-1:0])))
    else $error("input delay line head mismatch");

  // fed-back output equals the delivered output
  a_y_feedback: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (y_hist[0] == m_tdata[SAMPLE_WIDTH-1:0]))
    else $error("output delay line differs from delivered sample");

  // a clipped result sits at one of the range limits
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |->
      ((m_tdata[SAMPLE_WIDTH-1:0] == OUT_MAX) || (m_tdata[SAMPLE_WIDTH-1:0] == OUT_MIN)))
    else $error("saturated flag without limit value");
`endif

endmodule

@@ rtl/core/iir3_coef_regs.sv @@
// Coefficient register file behind the APB-style configuration port.
module iir3_coef_regs
  import iir3_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output coef_bank_t            coefs
);

  logic [REG_IDX_W-1:0] idx;
  logic                 idx_ok;

  assign idx    = paddr[CFG_ADDR_W-1:2];
  assign idx_ok = (32'(idx) < NUM_COEFS);

  always_ff @(posedge clk) begin
    if (rst) begin
      coefs <= COEF_RESET;
    end else if (psel && penable && pwrite && idx_ok) begin
      coefs[idx] <= pwdata;
    end
  end

  // unmapped slots read as zero
  assign prdata = idx_ok ? coefs[idx] : '0;

endmodule

@@ rtl/core/iir3_term.sv @@
// One tap: exact sample x coefficient product, rounded half up to sample format.
module iir3_term
  import iir3_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = DEF_SAMPLE_WIDTH,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS,
  localparam int PROD_W = SAMPLE_WIDTH + COEF_W,
  localparam int TERM_W = PROD_W - COEF_FRAC_BITS
) (
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic signed [COEF_W-1:0]       coef,
  output logic signed [TERM_W-1:0]       term
);

  localparam logic signed [PROD_W-1:0] HALF =
    {{(PROD_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] biased;
  logic signed [PROD_W-1:0] shifted;

  // |prod| <= 2^(PROD_W-2), so the rounding bias cannot wrap
  assign prod    = PROD_W'(sample) * PROD_W'(coef);
  assign biased  = prod + HALF;
  assign shifted = biased >>> COEF_FRAC_BITS;
  assign term    = shifted[TERM_W-1:0];

endmodule

@@ rtl/core/iir3_accum.sv @@
// Six-tap multiply, exact sum and saturation to the sample range.
module iir3_accum
  import iir3_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = DEF_SAMPLE_WIDTH,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic [2:0][SAMPLE_WIDTH-1:0] x_hist,
  input  logic [2:0][SAMPLE_WIDTH-1:0] y_hist,
  input  coef_bank_t                   coefs,
  output logic [SAMPLE_WIDTH-1:0]      result,
  output logic                         clipped
);

  localparam int TERM_W = SAMPLE_WIDTH + COEF_W - COEF_FRAC_BITS;
  localparam int SUM_W  = TERM_W + 3;

  localparam logic signed [SUM_W-1:0] SUM_MAX =
    {{(SUM_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN =
    {{(SUM_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic [SAMPLE_WIDTH-1:0] OUT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] OUT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic signed [TERM_W-1:0] fb_term [3];
  logic signed [TERM_W-1:0] ff_term [3];
  logic signed [SUM_W-1:0]  fb_sum;
  logic signed [SUM_W-1:0]  ff_sum;
  logic signed [SUM_W-1:0]  sum;

  for (genvar i = 0; i < 3; i++) begin : g_tap
    iir3_term #(
      .SAMPLE_WIDTH  (SAMPLE_WIDTH),
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_fb (
      .sample(y_hist[i]),
      .coef  (coefs[32'(REG_FB_ONE) + i]),
      .term  (fb_term[i])
    );
    iir3_term #(
      .SAMPLE_WIDTH  (SAMPLE_WIDTH),
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_ff (
      .sample(x_hist[i]),
      .coef  (coefs[32'(REG_FF_ONE) + i]),
      .term  (ff_term[i])
    );
  end

  assign fb_sum = SUM_W'(fb_term[0]) + SUM_W'(fb_term[1]) + SUM_W'(fb_term[2]);
  assign ff_sum = SUM_W'(ff_term[0]) + SUM_W'(ff_term[1]) + SUM_W'(ff_term[2]);
  assign sum    = fb_sum + ff_sum;

  always_comb begin
    priority if (sum > SUM_MAX) begin
      result  = OUT_MAX;
      clipped = 1'b1;
    end else if (sum < SUM_MIN) begin
      result  = OUT_MIN;
      clipped = 1'b1;
    end else begin
      result  = sum[SAMPLE_WIDTH-1:0];
      clipped = 1'b0;
    end
  end

endmodule

@@ test/tb_third_order_iir_filter.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for third_order_iir_filter: sample stream in and out, APB coef writes.
module tb_third_order_iir_filter
  import iir3_pkg::*;
();

  localparam int SW            = DEF_SAMPLE_WIDTH;
  localparam int FRAC          = DEF_COEF_FRAC_BITS;
  localparam int TDATA_W       = ((SW + 7) / 8) * 8;
  // Cycles with no beat and no APB access before the run is declared hung.
  localparam int STALL_LIMIT   = 2000;
  // Output register is one deep, so a few quiet cycles at the end are plenty.
  localparam int TAIL_CYCLES   = 4;
  localparam int SEG_ITEMS     = 115;
  // Indexes that the 5-bit address reaches but that hold no register.
  localparam int UNUSED_REG_LO = NUM_COEFS;
  localparam int UNUSED_REG_HI = (1 << REG_IDX_W) - 1;

  typedef logic signed [SW-1:0]     sample_t;
  typedef logic signed [COEF_W-1:0] scoef_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam coef_t   COEF_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
  localparam coef_t   COEF_MIN   = {1'b1, {(COEF_W-1){1'b0}}};
  localparam coef_t   COEF_HALF  = coef_t'(1) << (FRAC - 1);

  typedef struct packed {
    sample_t sample;
    logic    clipped;
  } filter_out_t;

  // Flavors of random coefficient sets.
  typedef enum int {
    COEF_WILD,   // any 32-bit value, mostly saturating
    COEF_SMALL,  // each within +/-0.25, always stable
    COEF_PLANT   // default feedback, small random feedforward
  } coef_style_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [TDATA_W-1:0]    s_tdata  = '0;   // [SW-1:0] sample_in
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [TDATA_W-1:0]    m_tdata;         // [SW-1:0] sample_out
  logic                  m_tuser;         // [0] saturated
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr    = '0;
  logic [CFG_DATA_W-1:0] pwdata   = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // Shadow of the filter: coefficients and both delay lines.
  scoef_t      coef_shadow [NUM_COEFS];
  sample_t     x_hist [3];
  sample_t     y_hist [3];

  sample_t     sample_queue [$];     // samples not yet accepted by the DUT
  filter_out_t pending_outputs [$];  // predicted outputs not yet seen

  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int errors        = 0;
  int stall_cycles  = 0;
  bit in_beat_done  = 1'b0;          // input beat taken at the last rising edge

  third_order_iir_filter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // sample * coef, exact, then rounded half up back to sample scale
  function automatic longint rounded_product(input sample_t s, input scoef_t c);
    longint p;
    p = longint'(s) * longint'(c);
    return (p + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
  endfunction

  // One filter step: output from history only, then shift both delay lines.
  function automatic filter_out_t filter_step(input sample_t x_new);
    longint      acc;
    filter_out_t res;
    acc = 0;
    for (int k = 0; k < 3; k++) begin
      acc += rounded_product(y_hist[k], coef_shadow[k]);
      acc += rounded_product(x_hist[k], coef_shadow[3 + k]);
    end
    // clip to sample range; the clipped value is what goes into y history
    if (acc > longint'(SAMPLE_MAX)) begin
      res.sample  = SAMPLE_MAX;
      res.clipped = 1'b1;
    end else if (acc < longint'(SAMPLE_MIN)) begin
      res.sample  = SAMPLE_MIN;
      res.clipped = 1'b1;
    end else begin
      res.sample  = acc[SW-1:0];
      res.clipped = 1'b0;
    end
    y_hist[2] = y_hist[1];
    y_hist[1] = y_hist[0];
    y_hist[0] = res.sample;
    x_hist[2] = x_hist[1];
    x_hist[1] = x_hist[0];
    x_hist[0] = x_new;
    return res;
  endfunction

  // Stream driver: a beat on offer stays put until taken, else maybe idle; m_tready is random.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      if (!s_tvalid || in_beat_done) begin
        if (sample_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= TDATA_W'($unsigned(sample_queue[0]));
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
    in_beat_done = 1'b0;
  end

  // Monitor: check output beats, predict on input beats, watchdog.
  always @(posedge clk) begin
    filter_out_t want;
    if (!rst) begin
      // check before predicting: an output never belongs to this edge's input
      if (m_tvalid && m_tready) begin
        if (pending_outputs.size() == 0) begin
          $error("output beat with nothing expected: sample_out %0d",
                 $signed(m_tdata[SW-1:0]));
          errors++;
        end else begin
          want = pending_outputs.pop_front();
          if (m_tdata[SW-1:0] !== want.sample) begin
            $error("sample_out mismatch: expected %0d, actual %0d",
                   want.sample, $signed(m_tdata[SW-1:0]));
            errors++;
          end
          if (m_tuser !== want.clipped) begin
            $error("saturated mismatch: expected %0d, actual %0d", want.clipped, m_tuser);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        pending_outputs.push_back(filter_step($signed(s_tdata[SW-1:0])));
        void'(sample_queue.pop_front());
        in_beat_done = 1'b1;
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_third_order_iir_filter: FAIL");
        $finish;
      end
    end
  end

  // APB write: setup, access, done at the edge that sees pready.
  task automatic write_coef(input int idx, input coef_t value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(idx * 4);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // unused indexes are dropped by the DUT
    if (idx < NUM_COEFS) coef_shadow[idx] = value;
  endtask

  // Block until every sample is taken and every output has come back.
  task automatic wait_drained();
    while (sample_queue.size() != 0 || pending_outputs.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_config();
    coef_style_t style;
    coef_t       value;
    style = coef_style_t'($urandom_range(2));
    for (int i = 0; i < NUM_COEFS; i++) begin
      case (style)
        COEF_WILD:  value = $urandom;
        COEF_SMALL: value = $urandom_range(1 << 27) - (1 << 26);
        default: begin
          value = (i < 3) ? COEF_RESET[i] : coef_t'($urandom_range(1 << 22) - (1 << 21));
        end
      endcase
      write_coef(i, value);
    end
    if ($urandom_range(1)) write_coef($urandom_range(UNUSED_REG_HI, UNUSED_REG_LO), $urandom);
  endtask

  // Mostly full-range noise, some small signals, rails and near-zero.
  function automatic sample_t random_sample();
    int pick;
    pick = $urandom_range(9);
    if (pick < 5) return $urandom;
    else if (pick < 8) return $urandom_range(1 << 21) - (1 << 20);
    else if (pick == 8) return $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
    else return $urandom_range(2) - 1;
  endfunction

  // One segment: fresh coefs, a burst, a full drain with the sender paused, a burst.
  task automatic random_segment(input int count);
    int split;
    random_config();
    split = $urandom_range(10, count - 10);
    for (int i = 0; i < split; i++) sample_queue.push_back(random_sample());
    wait_drained();
    for (int i = split; i < count; i++) sample_queue.push_back(random_sample());
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < NUM_COEFS; i++) coef_shadow[i] = COEF_RESET[i];
    for (int i = 0; i < 3; i++) begin
      x_hist[i] = '0;
      y_hist[i] = '0;
    end
    src_idle_pct  = 15;
    sink_idle_pct = 55;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset coefficients: rails, sign flips, tiny values.
    sample_queue.push_back(SAMPLE_MAX);
    sample_queue.push_back(SAMPLE_MAX);
    sample_queue.push_back(SAMPLE_MAX);
    sample_queue.push_back(SAMPLE_MIN);
    sample_queue.push_back(0);
    sample_queue.push_back(1);
    sample_queue.push_back(-1);
    sample_queue.push_back(sample_t'(1) << 16);
    wait_drained();

    // All coefs at +max: clipping both ways, clipped value fed back.
    // Writes to the unused indexes must leave the bank alone.
    for (int i = 0; i < NUM_COEFS; i++) write_coef(i, COEF_MAX);
    write_coef(UNUSED_REG_LO, '0);
    write_coef(UNUSED_REG_HI, '1);
    sample_queue.push_back(SAMPLE_MAX);
    sample_queue.push_back(SAMPLE_MIN);
    sample_queue.push_back(0);
    sample_queue.push_back(0);
    sample_queue.push_back(0);
    sample_queue.push_back(0);
    wait_drained();

    // All coefs at the most negative value.
    for (int i = 0; i < NUM_COEFS; i++) write_coef(i, COEF_MIN);
    sample_queue.push_back(SAMPLE_MAX);
    sample_queue.push_back(SAMPLE_MAX);
    sample_queue.push_back(SAMPLE_MIN);
    sample_queue.push_back(sample_t'(32'h1234_5678));
    sample_queue.push_back(0);
    wait_drained();

    // Pure delay at gain one half: odd inputs land on the rounding tie.
    for (int i = 0; i < NUM_COEFS; i++) write_coef(i, '0);
    write_coef(REG_FF_ONE, COEF_HALF);
    sample_queue.push_back(1);
    sample_queue.push_back(-1);
    sample_queue.push_back(3);
    sample_queue.push_back(-3);
    wait_drained();

    // Random part: slow sink, then slow source, then full rate.
    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct  = (phase == 0) ? 15 : (phase == 1) ? 55 : 0;
      sink_idle_pct = (phase == 0) ? 55 : (phase == 1) ? 15 : 0;
      repeat (4) random_segment(SEG_ITEMS);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_outputs.size() != 0) begin
      $error("%0d expected outputs never arrived", pending_outputs.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb_third_order_iir_filter: PASS");
    end else begin
      $display("tb_third_order_iir_filter: FAIL");
    end
    $finish;
  end

endmodule
